// File: src/crc_pkg.sv
package crc_pkg;

	localparam int unsigned COLUMNS_DEFAULT = 80;
	localparam int unsigned COL_W = 7;
	localparam int unsigned STATUS_W = 18;
	localparam int unsigned DATA_W = 12;
	localparam int unsigned WORD_W = 13;

	typedef enum logic [2:0] {
		OP_STATUS_READ  = 3'd0,
		OP_CONTROL      = 3'd1,
		OP_DATA_READ    = 3'd2,
		OP_DATA_WRITE   = 3'd3,
		OP_SERVICE      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PICK_OK    = 2'd0,
		PICK_EOF   = 2'd1,
		PICK_FAIL  = 2'd2,
		PICK_EMPTY = 2'd3
	} pick_t;

	// status word bits
	localparam logic [STATUS_W-1:0] ST_LEVEL   = 18'o0000007;
	localparam logic [STATUS_W-1:0] ST_DRDY    = 18'o0000010;
	localparam logic [STATUS_W-1:0] ST_ENDCARD = 18'o0000020;
	localparam logic [STATUS_W-1:0] ST_EOF     = 18'o0000040;
	localparam logic [STATUS_W-1:0] ST_RDY     = 18'o0000100;
	localparam logic [STATUS_W-1:0] ST_MISS    = 18'o0000200;
	localparam logic [STATUS_W-1:0] ST_TROUBLE = 18'o0000400;
	localparam logic [STATUS_W-1:0] ST_READING = 18'o0001000;
	localparam logic [STATUS_W-1:0] ST_CARDIN  = 18'o0004000;
	localparam logic [STATUS_W-1:0] ST_RDY_EN  = 18'o0200000;
	localparam logic [STATUS_W-1:0] ST_TRB_EN  = 18'o0400000;

	// control word bits
	localparam logic [WORD_W-1:0] CW_LEVEL    = 13'o0007;
	localparam logic [WORD_W-1:0] CW_CLEARS   = 13'o0270;
	localparam logic [WORD_W-1:0] CW_EN_READY = 13'o0100;
	localparam logic [WORD_W-1:0] CW_EN_TRB   = 13'o0400;
	localparam logic [WORD_W-1:0] CW_READ     = 13'o1000;
	localparam logic [WORD_W-1:0] CW_RESET    = 13'o10000;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] write_data;
		logic [DATA_W-1:0] column_data;
		pick_t             pick_result;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] read_data;
		logic                irq_line;
		logic [2:0]          irq_level;
		logic                service_wanted;
		logic [COL_W-1:0]    next_column;
	} rsp_t;

endpackage

// File: src/card_reader_controller.sv
// path: each request is held in the input register, then in the response register;
// a stalled response (rsp_stall) holds the next request in the input register
// throughput: one transaction per cycle while rsp_stall does not hold the response; the single
// status update is a combinational pass between the input register and the response register
// reset: arst_n clears status word, column counter, held column, interrupt,
// service flag, reader_attached and both valid bits
module card_reader_controller #(
	parameter int unsigned COLUMNS = crc_pkg::COLUMNS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  crc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output crc_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import crc_pkg::*;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS);

	logic                valid_s1;
	req_t                req_s1;
	logic                valid_s2;
	rsp_t                rsp_s2;
	logic                advance;

	logic [STATUS_W-1:0] status_q;
	logic [COL_W-1:0]    col_cnt_q;
	logic [DATA_W-1:0]   held_col_q;
	logic                irq_q;
	logic                svc_q;
	logic                attached_q;

	logic [STATUS_W-1:0] sw;
	logic [COL_W-1:0]    cc;
	logic [DATA_W-1:0]   hc;
	logic                irq;
	logic                svc;
	logic [STATUS_W-1:0] rd;
	logic [WORD_W-1:0]   w;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && valid_s2 && rsp_stall;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_comb begin
		sw  = status_q;
		cc  = col_cnt_q;
		hc  = held_col_q;
		irq = irq_q;
		svc = svc_q;
		rd  = '0;
		w   = req_s1.write_data;
		case (req_s1.op)
			OP_STATUS_READ: begin
				if (attached_q && (sw & (ST_READING | ST_CARDIN | ST_ENDCARD)) == '0) begin
					sw = sw | ST_RDY;
				end
				rd = sw;
				if ((sw & ST_RDY_EN) != '0 && (sw & ST_RDY) != '0 && (sw & ST_LEVEL) != '0) begin
					irq = 1'b1;
				end
			end
			OP_CONTROL: begin
				irq = 1'b0;
				if ((w & CW_RESET) != '0) begin
					sw  = '0;
					svc = 1'b0;
				end else begin
					sw = (sw & ~ST_LEVEL) | STATUS_W'(w & CW_LEVEL);
					sw = sw & ~STATUS_W'(w & CW_CLEARS);
					if ((w & CW_EN_TRB) != '0) begin
						sw = sw | ST_TRB_EN;
					end
					if ((w & CW_EN_READY) != '0) begin
						sw = sw | ST_RDY_EN;
					end
					if ((w & CW_READ) != '0) begin
						sw  = (sw | ST_READING) & ~(ST_CARDIN | ST_RDY | ST_DRDY);
						cc  = '0;
						svc = 1'b1;
					end
					if (attached_q && (sw & (ST_READING | ST_CARDIN | ST_ENDCARD)) == '0) begin
						sw = sw | ST_RDY;
					end
					if ((sw & ST_LEVEL) != '0) begin
						if ((sw & ST_RDY_EN) != '0 && (sw & ST_RDY) != '0) begin
							irq = 1'b1;
						end
						if ((sw & ST_TRB_EN) != '0 &&
						    (sw & (ST_ENDCARD | ST_EOF | ST_MISS | ST_TROUBLE)) != '0) begin
							irq = 1'b1;
						end
					end
				end
			end
			OP_DATA_READ: begin
				irq = 1'b0;
				if ((sw & ST_DRDY) != '0) begin
					rd = STATUS_W'(hc);
					sw = sw & ~ST_DRDY;
				end
			end
			OP_SERVICE: begin
				if (svc_q) begin
					svc = 1'b0;
					if ((sw & (ST_READING | ST_CARDIN)) == ST_READING) begin
						case (req_s1.pick_result)
							PICK_OK: begin
								sw  = sw | ST_CARDIN;
								cc  = '0;
								svc = 1'b1;
							end
							PICK_EOF: begin
								sw = sw | ST_EOF;
								if ((sw & ST_TRB_EN) != '0 && (sw & ST_LEVEL) != '0) begin
									irq = 1'b1;
								end
							end
							PICK_FAIL: begin
								sw = sw | ST_TROUBLE;
								if ((sw & ST_TRB_EN) != '0 && (sw & ST_LEVEL) != '0) begin
									irq = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end else if ((sw & ST_CARDIN) != '0) begin
						if (cc >= LAST_COL) begin
							sw = (sw & ~(ST_CARDIN | ST_READING)) | ST_ENDCARD;
						end else begin
							hc = req_s1.column_data;
							cc = cc + COL_W'(1);
							if ((sw & ST_DRDY) != '0) begin
								sw = sw | ST_MISS;
							end
							sw = sw | ST_DRDY;
						end
						if ((sw & ST_LEVEL) != '0) begin
							irq = 1'b1;
						end
						svc = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q <= 1'b0;
		end else if (cfg_we) begin
			attached_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			status_q   <= '0;
			col_cnt_q  <= '0;
			held_col_q <= '0;
			irq_q      <= 1'b0;
			svc_q      <= 1'b0;
		end else if (advance) begin
			valid_s2   <= 1'b1;
			status_q   <= sw;
			col_cnt_q  <= cc;
			held_col_q <= hc;
			irq_q      <= irq;
			svc_q      <= svc;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.read_data      <= rd;
			rsp_s2.irq_line       <= irq;
			rsp_s2.irq_level      <= sw[2:0];
			rsp_s2.service_wanted <= svc;
			rsp_s2.next_column    <= cc;
		end
	end

	// interrupt only stands at a nonzero level
	assert property (@(posedge clk) disable iff (!arst_n)
		irq_q |-> ((status_q & ST_LEVEL) != '0))
		else $error("interrupt raised at level zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		col_cnt_q <= LAST_COL)
		else $error("column counter past last column");

	// card in reader only while a read is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		((status_q & ST_CARDIN) != '0) |-> ((status_q & ST_READING) != '0))
		else $error("card in reader without reading");

endmodule

// File: tb/sv/card_reader_controller_test.sv
`timescale 1ns / 1ps

module card_reader_controller_test;
	import crc_pkg::*;

	localparam int ITEM_TARGET = 1600;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD = 120;
	localparam int PRINT_CAP = 200;

	typedef struct {
		bit   cfg;
		bit   attach;
		req_t r;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	// mirror of the controller state
	logic [STATUS_W-1:0] exp_status = '0;
	logic [COL_W-1:0]    exp_column = '0;
	logic [DATA_W-1:0]   exp_held = '0;
	logic                exp_irq = 1'b0;
	logic                exp_service = 1'b0;
	logic                attached_now = 1'b0;

	rsp_t      awaited_rsp[$];
	stim_row_t directed_rows[$];
	int        n_mismatch = 0;
	int        n_items = 0;
	int        n_rsp = 0;
	int        idle_cycles = 0;
	int        hold_rsp = 0;
	bit        quiet = 1'b0;

	card_reader_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		if (n_mismatch < PRINT_CAP)
			$display("mismatch at response %0d: %s", n_rsp, msg);
		n_mismatch++;
	endtask

	function automatic void raise_irq();
		if ((exp_status & ST_LEVEL) != '0)
			exp_irq = 1'b1;
	endfunction

	function automatic void ready_check();
		if (attached_now && (exp_status & (ST_READING | ST_CARDIN | ST_ENDCARD)) == '0)
			exp_status |= ST_RDY;
	endfunction

	function automatic void predict_reader_step(input req_t r, output rsp_t o);
		logic [STATUS_W-1:0] rd;
		logic [STATUS_W-1:0] w;
		rd = '0;
		w = {5'b0, r.write_data};
		case (r.op)
			OP_STATUS_READ: begin
				ready_check();
				rd = exp_status;
				if ((exp_status & ST_RDY_EN) != '0 && (exp_status & ST_RDY) != '0)
					raise_irq();
			end
			OP_CONTROL: begin
				exp_irq = 1'b0;
				if ((r.write_data & CW_RESET) != '0) begin
					exp_status = '0;
					exp_service = 1'b0;
				end else begin
					exp_status = (exp_status & ~ST_LEVEL) | (w & ST_LEVEL);
					exp_status &= ~{5'b0, r.write_data & CW_CLEARS};
					if ((r.write_data & CW_EN_TRB) != '0)
						exp_status |= ST_TRB_EN;
					if ((r.write_data & CW_EN_READY) != '0)
						exp_status |= ST_RDY_EN;
					if ((r.write_data & CW_READ) != '0) begin
						exp_status |= ST_READING;
						exp_status &= ~(ST_CARDIN | ST_RDY | ST_DRDY);
						exp_column = '0;
						exp_service = 1'b1;
					end
					ready_check();
					if ((exp_status & ST_RDY_EN) != '0 && (exp_status & ST_RDY) != '0)
						raise_irq();
					if ((exp_status & ST_TRB_EN) != '0 &&
						(exp_status & (ST_ENDCARD | ST_EOF | ST_MISS | ST_TROUBLE)) != '0)
						raise_irq();
				end
			end
			OP_DATA_READ: begin
				exp_irq = 1'b0;
				if ((exp_status & ST_DRDY) != '0) begin
					rd = {6'b0, exp_held};
					exp_status &= ~ST_DRDY;
				end
			end
			OP_SERVICE: begin
				if (exp_service) begin
					exp_service = 1'b0;
					if ((exp_status & (ST_READING | ST_CARDIN)) == ST_READING) begin
						case (r.pick_result)
							PICK_OK: begin
								exp_status |= ST_CARDIN;
								exp_column = '0;
								exp_service = 1'b1;
							end
							PICK_EOF: begin
								exp_status |= ST_EOF;
								if ((exp_status & ST_TRB_EN) != '0)
									raise_irq();
							end
							PICK_FAIL: begin
								exp_status |= ST_TROUBLE;
								if ((exp_status & ST_TRB_EN) != '0)
									raise_irq();
							end
							default: begin
							end
						endcase
					end else if ((exp_status & ST_CARDIN) != '0) begin
						if (exp_column >= COLUMNS_DEFAULT) begin
							exp_status &= ~(ST_CARDIN | ST_READING);
							exp_status |= ST_ENDCARD;
						end else begin
							exp_held = r.column_data;
							exp_column = exp_column + 1'b1;
							if ((exp_status & ST_DRDY) != '0)
								exp_status |= ST_MISS;
							exp_status |= ST_DRDY;
						end
						raise_irq();
						exp_service = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		o.read_data = rd;
		o.irq_line = exp_irq;
		o.irq_level = exp_status[2:0];
		o.service_wanted = exp_service;
		o.next_column = exp_column;
	endfunction

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t rand_req(input op_t op);
		req_t r;
		r.op = op;
		r.write_data = WORD_W'($urandom);
		r.column_data = DATA_W'($urandom);
		r.pick_result = pick_t'($urandom_range(0, 3));
		return r;
	endfunction

	function automatic req_t make_req(input op_t op, input logic [WORD_W-1:0] w,
			input logic [DATA_W-1:0] col, input pick_t p);
		req_t r;
		r.op = op;
		r.write_data = w;
		r.column_data = col;
		r.pick_result = p;
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic issue(input req_t r, input bit typed, input rsp_t typed_want);
		rsp_t want;
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		predict_reader_step(r, want);
		awaited_rsp.push_back(typed ? typed_want : want);
		if (r.op inside {OP_STATUS_READ, OP_CONTROL, OP_DATA_READ, OP_SERVICE})
			n_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_attached(input bit v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		attached_now = v;
	endtask

	task automatic add_txn(input op_t op, input logic [WORD_W-1:0] w,
			input logic [DATA_W-1:0] col, input pick_t p, input bit typed);
		stim_row_t row;
		row.cfg = 1'b0;
		row.attach = 1'b0;
		row.r = make_req(op, w, col, p);
		row.typed = typed;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg(input bit v);
		stim_row_t row;
		row.cfg = 1'b1;
		row.attach = v;
		row.r = '0;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic sprinkle();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			issue(rand_req(OP_DATA_READ), 1'b0, '0);
		end else if (pick < 55) begin
			issue(rand_req(OP_STATUS_READ), 1'b0, '0);
		end else if (pick < 58) begin
			r = rand_req(OP_CONTROL);
			r.write_data &= ~(CW_RESET | CW_READ);
			issue(r, 1'b0, '0);
		end else if (pick < 60) begin
			issue(rand_req(op_t'($urandom_range(0, 1) ? 3 : $urandom_range(5, 7))),
				1'b0, '0);
		end
	endtask

	task automatic run_card();
		req_t r;
		int cols;
		r = rand_req(OP_CONTROL);
		r.write_data = (r.write_data & ~CW_RESET) | CW_READ;
		issue(r, 1'b0, '0);
		r = rand_req(OP_SERVICE);
		if ($urandom_range(0, 9) < 7)
			r.pick_result = PICK_OK;
		issue(r, 1'b0, '0);
		cols = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COLUMNS_DEFAULT)
			: COLUMNS_DEFAULT + 2;
		repeat (cols) begin
			sprinkle();
			issue(rand_req(OP_SERVICE), 1'b0, '0);
		end
		sprinkle();
	endtask

	task automatic random_burst(input int n);
		req_t r;
		repeat (n) begin
			r = rand_req(op_t'($urandom_range(0, 7)));
			if ($urandom_range(0, 7) != 0)
				r.write_data &= ~CW_RESET;
			issue(r, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int phase;
		stim_row_t row;

		add_txn(OP_STATUS_READ, '0, '0, PICK_OK, 1'b1);
		add_txn(OP_DATA_READ, '0, '0, PICK_OK, 1'b1);
		add_txn(OP_DATA_WRITE, 13'h1fff, 12'hfff, PICK_EMPTY, 1'b1);
		add_txn(op_t'(3'd7), 13'h1fff, 12'hfff, PICK_EMPTY, 1'b1);
		add_txn(OP_SERVICE, 13'h1fff, 12'hfff, PICK_OK, 1'b1);
		add_txn(OP_CONTROL, CW_EN_READY | 13'd7, '0, PICK_OK, 1'b0);
		add_cfg(1'b1);
		add_txn(OP_STATUS_READ, '0, '0, PICK_OK, 1'b0);
		add_txn(OP_CONTROL, 13'h1fff, '0, PICK_OK, 1'b1);
		// raise request at level zero
		add_txn(OP_CONTROL, CW_EN_READY, '0, PICK_OK, 1'b0);
		add_txn(OP_CONTROL, CW_EN_READY | CW_EN_TRB | CW_READ | 13'd5, '0, PICK_OK, 1'b0);
		add_txn(OP_SERVICE, '0, 12'h5a5, PICK_EMPTY, 1'b0);
		add_txn(OP_CONTROL, CW_READ | CW_EN_TRB | 13'd5, '0, PICK_OK, 1'b0);
		add_txn(OP_SERVICE, '0, '0, PICK_EOF, 1'b0);
		add_txn(OP_CONTROL, CW_READ | CW_CLEARS | 13'd3, '0, PICK_OK, 1'b0);
		add_txn(OP_SERVICE, '0, '0, PICK_FAIL, 1'b0);
		add_txn(OP_CONTROL, CW_READ | CW_CLEARS | 13'd2, '0, PICK_OK, 1'b0);
		add_txn(OP_SERVICE, '0, 12'hfff, PICK_OK, 1'b0);
		add_txn(OP_SERVICE, '0, 12'h000, PICK_FAIL, 1'b0);
		add_txn(OP_SERVICE, '0, 12'hfff, PICK_EMPTY, 1'b0);
		add_txn(OP_DATA_READ, '0, '0, PICK_OK, 1'b0);
		add_txn(OP_DATA_READ, '0, '0, PICK_OK, 1'b0);
		add_txn(OP_STATUS_READ, '0, '0, PICK_OK, 1'b0);
		add_txn(OP_CONTROL, 13'o6000, '0, PICK_OK, 1'b0);
		add_cfg(1'b0);
		add_txn(OP_STATUS_READ, '0, '0, PICK_OK, 1'b0);

		wait (arst_n === 1'b1);
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg)
				set_attached(row.attach);
			else
				issue(row.r, row.typed, row.want);
		end

		for (phase = 0; n_items < ITEM_TARGET; phase++) begin
			set_attached(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
			quiet = (phase % 4 == 2);
			if (phase == 2) begin
				// receiver backs off while items keep coming
				hold_rsp = LONG_HOLD;
				random_burst(30);
			end
			run_card();
			if (phase == 3)
				drain();
			random_burst($urandom_range(10, 40));
			run_card();
		end

		quiet = 1'b0;
		drain();
		if (n_mismatch == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : rsp_side
		int run;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp > 0) begin
				rsp_stall <= 1'b1;
				hold_rsp--;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else if (rsp_stall) begin
				rsp_stall <= 1'b0;
				run = quiet ? 0 : $urandom_range(0, 7);
			end else begin
				run = gap_len();
				if (run > 0) begin
					rsp_stall <= 1'b1;
					run--;
				end
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction %h", rsp));
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.read_data !== want.read_data)
					report_mismatch($sformatf("read_data %o, expected %o",
						rsp.read_data, want.read_data));
				if (rsp.irq_line !== want.irq_line)
					report_mismatch($sformatf("irq_line %b, expected %b",
						rsp.irq_line, want.irq_line));
				if (rsp.irq_level !== want.irq_level)
					report_mismatch($sformatf("irq_level %0d, expected %0d",
						rsp.irq_level, want.irq_level));
				if (rsp.service_wanted !== want.service_wanted)
					report_mismatch($sformatf("service_wanted %b, expected %b",
						rsp.service_wanted, want.service_wanted));
				if (rsp.next_column !== want.next_column)
					report_mismatch($sformatf("next_column %0d, expected %0d",
						rsp.next_column, want.next_column));
			end
			n_rsp++;
		end
	end

	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) ||
			(rsp_valid === 1'b1 && rsp_stall === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
